>>> rtl/core/bld_pkg.sv
package bld_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 4;
  localparam int NUM_CH       = 4;

  localparam int POS_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 9;
  localparam int CHN_W    = 3;
  localparam int FRAC_W   = 16;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int STEP_W   = 26;
  localparam int PROD_W   = POS_W + STEP_W;
  localparam int IDX_W    = PROD_W - FRAC_W;
  localparam int X_W      = $clog2(MAX_WIDTH);
  localparam int Y_W      = $clog2(MAX_HEIGHT);
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PIX_W    = MAX_CHANNELS * SAMPLE_W;
  localparam int NUM_W    = CFG_W + FRAC_W;
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam int H_W      = 2 * SAMPLE_W;
  localparam int ACC_W    = H_W + FRAC_W;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_W  = APB_AW - 2;

  localparam logic [REG_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [REG_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [REG_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [REG_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [REG_W-1:0] REG_CHANNELS   = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam int IN_WIDTH_RST   = 256;
  localparam int IN_HEIGHT_RST  = 256;
  localparam int OUT_WIDTH_RST  = 128;
  localparam int OUT_HEIGHT_RST = 128;
  localparam int CHANNELS_RST   = 1;

  localparam logic [STEP_W-1:0] STEP_X_RST =
    STEP_W'(((IN_WIDTH_RST - 1) << FRAC_W) / OUT_WIDTH_RST);
  localparam logic [STEP_W-1:0] STEP_Y_RST =
    STEP_W'(((IN_HEIGHT_RST - 1) << FRAC_W) / OUT_HEIGHT_RST);

  localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STEP_W-1:0] quo;
  } bld_div_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] nbr;
  } bld_rd_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } bld_frac_t;

endpackage

>>> rtl/core/bilinear_downscaler.sv
// Bilinear downscaler. A load item writes one source pixel of up to four
// 16-bit channels into a single-port frame store; load items can be taken
// back to back while the input is not stalled. A compute item first does the
// coordinate multiply, then the four neighbor reads from the single port of
// the frame store, then passes the blend pipeline and finally moves the result
// into the output register. No other item is taken until that result has moved
// into the output register. A result waiting in the output register does not
// hold up the next item until the following result is ready. Writing a size
// register starts the two ratio dividers, which produce one quotient bit per
// cycle; input items wait until they finish. The frame store has no reset, so
// pixels must be loaded before any compute item reads them.
module bilinear_downscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bld_pkg::APB_AW-1:0]    paddr,
  input  logic [bld_pkg::APB_DW-1:0]    pwdata,
  output logic [bld_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [bld_pkg::POS_W-1:0]     pos_x_i,
  input  logic [bld_pkg::POS_W-1:0]     pos_y_i,
  input  logic [bld_pkg::SAMPLE_W-1:0]  sample_0_i,
  input  logic [bld_pkg::SAMPLE_W-1:0]  sample_1_i,
  input  logic [bld_pkg::SAMPLE_W-1:0]  sample_2_i,
  input  logic [bld_pkg::SAMPLE_W-1:0]  sample_3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bld_pkg::POS_W-1:0]     result_x_o,
  output logic [bld_pkg::POS_W-1:0]     result_y_o,
  output logic [bld_pkg::SAMPLE_W-1:0]  value_0_o,
  output logic [bld_pkg::SAMPLE_W-1:0]  value_1_o,
  output logic [bld_pkg::SAMPLE_W-1:0]  value_2_o,
  output logic [bld_pkg::SAMPLE_W-1:0]  value_3_o
);
  import bld_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [CFG_W-1:0]  in_width_q, in_width_d;
  logic [CFG_W-1:0]  in_height_q, in_height_d;
  logic [CFG_W-1:0]  out_width_q, out_width_d;
  logic [CFG_W-1:0]  out_height_q, out_height_d;
  logic [CHN_W-1:0]  channels_q, channels_d;
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic              start_q;
  logic              cfg_wr, size_wr;
  logic [REG_W-1:0]  reg_idx;
  bld_div_t          div_x, div_y;

  logic [1:0]        state_q, state_d;
  logic [1:0]        rd_cnt_q, rd_cnt_d;
  logic              busy_q, busy_d;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [PROD_W-1:0] cx_q, cy_q;
  bld_rd_t           rd_q, rd_d;

  logic              in_acc, comp_acc, load_acc, ram_we;
  logic [ADDR_W-1:0] ram_addr, waddr, raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic [NUM_CH-1:0][SAMPLE_W-1:0] samples;

  logic [X_W-1:0]    lim_x, x0, x1, xsel;
  logic [Y_W-1:0]    lim_y, y0, y1, ysel;
  logic [IDX_W-1:0]  ix, iy;
  logic [CHN_W-1:0]  nch;

  bld_frac_t         frac;
  logic              blend_fin, take;
  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] blend_val;

  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  result_x_q, result_y_q;
  logic [NUM_CH-1:0][SAMPLE_W-1:0] out_val_q, out_val_d;

  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign size_wr = cfg_wr && (reg_idx inside {REG_IN_WIDTH, REG_IN_HEIGHT,
                                              REG_OUT_WIDTH, REG_OUT_HEIGHT});
  assign pready  = 1'b1;

  always_comb begin
    in_width_d   = in_width_q;
    in_height_d  = in_height_q;
    out_width_d  = out_width_q;
    out_height_d = out_height_q;
    channels_d   = channels_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_IN_WIDTH:   in_width_d   = pwdata[CFG_W-1:0];
        REG_IN_HEIGHT:  in_height_d  = pwdata[CFG_W-1:0];
        REG_OUT_WIDTH:  out_width_d  = pwdata[CFG_W-1:0];
        REG_OUT_HEIGHT: out_height_d = pwdata[CFG_W-1:0];
        REG_CHANNELS:   channels_d   = pwdata[CHN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IN_WIDTH:   prdata = APB_DW'(in_width_q);
      REG_IN_HEIGHT:  prdata = APB_DW'(in_height_q);
      REG_OUT_WIDTH:  prdata = APB_DW'(out_width_q);
      REG_OUT_HEIGHT: prdata = APB_DW'(out_height_q);
      REG_CHANNELS:   prdata = APB_DW'(channels_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= CFG_W'(IN_WIDTH_RST);
      in_height_q  <= CFG_W'(IN_HEIGHT_RST);
      out_width_q  <= CFG_W'(OUT_WIDTH_RST);
      out_height_q <= CFG_W'(OUT_HEIGHT_RST);
      channels_q   <= CHN_W'(CHANNELS_RST);
      start_q      <= 1'b0;
      step_x_q     <= STEP_X_RST;
      step_y_q     <= STEP_Y_RST;
    end else begin
      in_width_q   <= in_width_d;
      in_height_q  <= in_height_d;
      out_width_q  <= out_width_d;
      out_height_q <= out_height_d;
      channels_q   <= channels_d;
      start_q      <= size_wr;
      if (div_x.done) begin
        step_x_q <= div_x.quo;
      end
      if (div_y.done) begin
        step_y_q <= div_y.quo;
      end
    end
  end

  bld_ratio u_ratio_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .size_i     (in_width_q),
    .out_size_i (out_width_q),
    .div_o      (div_x)
  );

  bld_ratio u_ratio_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .size_i     (in_height_q),
    .out_size_i (out_height_q),
    .div_o      (div_y)
  );

  assign in_stall_o = busy_q | start_q | div_x.busy | div_x.done
                    | div_y.busy | div_y.done;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign comp_acc   = in_acc && (opcode_i == OP_COMPUTE);
  assign load_acc   = in_acc && (opcode_i == OP_LOAD);
  assign ram_we     = load_acc && (32'(pos_x_i) < MAX_WIDTH)
                   && (32'(pos_y_i) < MAX_HEIGHT);

  assign samples = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  always_comb begin
    ram_wdata = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      ram_wdata[c*SAMPLE_W +: SAMPLE_W] = samples[c];
    end
  end

  always_comb begin
    if (in_width_q == '0) begin
      lim_x = '0;
    end else if (32'(in_width_q) > MAX_WIDTH) begin
      lim_x = X_W'(MAX_WIDTH - 1);
    end else begin
      lim_x = X_W'(in_width_q - 1'b1);
    end
    if (in_height_q == '0) begin
      lim_y = '0;
    end else if (32'(in_height_q) > MAX_HEIGHT) begin
      lim_y = Y_W'(MAX_HEIGHT - 1);
    end else begin
      lim_y = Y_W'(in_height_q - 1'b1);
    end
    nch = (32'(channels_q) > MAX_CHANNELS) ? CHN_W'(MAX_CHANNELS) : channels_q;
  end

  always_comb begin
    ix   = cx_q[PROD_W-1:FRAC_W];
    iy   = cy_q[PROD_W-1:FRAC_W];
    x0   = (ix > IDX_W'(lim_x)) ? lim_x : X_W'(ix);
    x1   = (ix >= IDX_W'(lim_x)) ? lim_x : X_W'(ix) + 1'b1;
    y0   = (iy > IDX_W'(lim_y)) ? lim_y : Y_W'(iy);
    y1   = (iy >= IDX_W'(lim_y)) ? lim_y : Y_W'(iy) + 1'b1;
    xsel = rd_cnt_q[0] ? x1 : x0;
    ysel = rd_cnt_q[1] ? y1 : y0;
  end

  assign waddr    = ADDR_W'(pos_y_i) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pos_x_i);
  assign raddr    = ADDR_W'(ysel) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xsel);
  assign ram_addr = ram_we ? waddr : raddr;

  bld_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (comp_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d  = ST_READ;
        rd_cnt_d = '0;
      end
      ST_READ: begin
        rd_cnt_d = rd_cnt_q + 1'b1;
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    rd_d.valid = (state_q == ST_READ);
    rd_d.nbr   = rd_cnt_q;
  end

  assign take        = blend_fin & (~out_valid_q | ~out_stall_i);
  assign out_valid_d = take | (out_valid_q & out_stall_i);

  always_comb begin
    busy_d = busy_q;
    if (comp_acc) begin
      busy_d = 1'b1;
    end else if (take) begin
      busy_d = 1'b0;
    end
    out_val_d = out_val_q;
    if (take) begin
      out_val_d = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (CHN_W'(c) < nch) begin
          out_val_d[c] = blend_val[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      busy_q      <= 1'b0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      busy_q      <= busy_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (comp_acc) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
    end
    if (state_q == ST_MUL) begin
      cx_q <= PROD_W'(pos_x_q) * PROD_W'(step_x_q);
      cy_q <= PROD_W'(pos_y_q) * PROD_W'(step_y_q);
    end
    if (take) begin
      result_x_q <= pos_x_q;
      result_y_q <= pos_y_q;
    end
    out_val_q <= out_val_d;
  end

  assign frac.fx = cx_q[FRAC_W-1:0];
  assign frac.fy = cy_q[FRAC_W-1:0];

  bld_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (rd_q),
    .rdata_i (ram_rdata),
    .frac_i  (frac),
    .take_i  (take),
    .fin_o   (blend_fin),
    .value_o (blend_val)
  );

  assign out_valid_o = out_valid_q;
  assign result_x_o  = result_x_q;
  assign result_y_o  = result_y_q;
  assign value_0_o   = out_val_q[0];
  assign value_1_o   = out_val_q[1];
  assign value_2_o   = out_val_q[2];
  assign value_3_o   = out_val_q[3];

`ifndef SYNTH
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE) && !busy_q)
    else $error("Frame store written while a compute item is in flight.");

  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(take))
    else $error("Compute item retired without handing over its result.");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_fin |-> (state_q == ST_IDLE) && busy_q)
    else $error("Blend finished while neighbor reads were still running.");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> busy_q && !blend_fin)
    else $error("Read sequencer active without a compute item.");
`endif

endmodule

>>> rtl/core/bld_ram.sv
module bld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bld_ratio.sv
module bld_ratio (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bld_pkg::CFG_W-1:0] size_i,
  input  logic [bld_pkg::CFG_W-1:0] out_size_i,
  output bld_pkg::bld_div_t         div_o
);
  import bld_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [CFG_W-1:0]  den_q, den_d;
  logic [CFG_W:0]    rem_sh;
  logic [CFG_W:0]    rem_sub;
  logic              ge;
  logic [CFG_W-1:0]  n_m1;

  always_comb begin
    n_m1    = (size_i == '0) ? '0 : size_i - 1'b1;
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = {n_m1, {FRAC_W{1'b0}}};
      rem_d  = '0;
      den_d  = (out_size_i == '0) ? CFG_W'(1) : out_size_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign div_o.busy = busy_q;
  assign div_o.done = done_q;
  assign div_o.quo  = STEP_W'(quo_q);

endmodule

>>> rtl/core/bld_blend.sv
module bld_blend (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  bld_pkg::bld_rd_t                                       rd_i,
  input  logic [bld_pkg::PIX_W-1:0]                              rdata_i,
  input  bld_pkg::bld_frac_t                                     frac_i,
  input  logic                                                   take_i,
  output logic                                                   fin_o,
  output logic [bld_pkg::MAX_CHANNELS-1:0][bld_pkg::SAMPLE_W-1:0] value_o
);
  import bld_pkg::*;

  logic [MAX_CHANNELS-1:0][H_W-1:0]   p_q, p_d;
  logic [MAX_CHANNELS-1:0][H_W-1:0]   h_q, h_d;
  logic [MAX_CHANNELS-1:0][ACC_W-1:0] q_q, q_d;
  logic [MAX_CHANNELS-1:0][ACC_W-1:0] acc_q, acc_d;
  logic                               p_vld_q;
  logic [1:0]                         p_nbr_q;
  logic                               h_rdy_q, h_row_q;
  logic                               q_vld_q, q_row_q;
  logic                               fin_q, fin_d;
  logic [WGT_W-1:0]                   gx, gy, wx, wy;

  // Each row is blended horizontally first, then the two rows vertically.
  // The exact sum stays below 65536 * 2^32, so the top bits never saturate.
  always_comb begin
    gx = WGT_ONE - {1'b0, frac_i.fx};
    gy = WGT_ONE - {1'b0, frac_i.fy};
    wx = rd_i.nbr[0] ? {1'b0, frac_i.fx} : gx;
    wy = h_row_q ? {1'b0, frac_i.fy} : gy;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      p_d[c]   = H_W'(rdata_i[c*SAMPLE_W +: SAMPLE_W]) * H_W'(wx);
      h_d[c]   = p_nbr_q[0] ? h_q[c] + p_q[c] : p_q[c];
      q_d[c]   = ACC_W'(h_q[c]) * ACC_W'(wy);
      acc_d[c] = q_row_q ? acc_q[c] + q_q[c] : q_q[c];
    end
    fin_d = fin_q;
    if (q_vld_q && q_row_q) begin
      fin_d = 1'b1;
    end else if (take_i) begin
      fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      p_nbr_q <= '0;
      h_rdy_q <= 1'b0;
      h_row_q <= 1'b0;
      q_vld_q <= 1'b0;
      q_row_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      p_vld_q <= rd_i.valid;
      p_nbr_q <= rd_i.nbr;
      h_rdy_q <= p_vld_q & p_nbr_q[0];
      h_row_q <= p_nbr_q[1];
      q_vld_q <= h_rdy_q;
      q_row_q <= h_row_q;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.valid) begin
      p_q <= p_d;
    end
    if (p_vld_q) begin
      h_q <= h_d;
    end
    if (h_rdy_q) begin
      q_q <= q_d;
    end
    if (q_vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      value_o[c] = acc_q[c][ACC_W-1:H_W];
    end
  end

  assign fin_o = fin_q;

endmodule

>>> verif/tb_bilinear_downscaler.sv
`timescale 1ns / 1ps

module tb_bilinear_downscaler;
  import bld_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 1320;

  typedef struct packed {
    logic [POS_W-1:0]                 x;
    logic [POS_W-1:0]                 y;
    logic [NUM_CH-1:0][SAMPLE_W-1:0]  v;
  } pixel_t;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_AW-1:0]     paddr      = '0;
  logic [APB_DW-1:0]     pwdata     = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  opcode_i   = OP_LOAD;
  logic [POS_W-1:0]      pos_x_i    = '0;
  logic [POS_W-1:0]      pos_y_i    = '0;
  logic [SAMPLE_W-1:0]   sample_0_i = '0;
  logic [SAMPLE_W-1:0]   sample_1_i = '0;
  logic [SAMPLE_W-1:0]   sample_2_i = '0;
  logic [SAMPLE_W-1:0]   sample_3_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [POS_W-1:0]      result_x_o;
  logic [POS_W-1:0]      result_y_o;
  logic [SAMPLE_W-1:0]   value_0_o;
  logic [SAMPLE_W-1:0]   value_1_o;
  logic [SAMPLE_W-1:0]   value_2_o;
  logic [SAMPLE_W-1:0]   value_3_o;

  bilinear_downscaler dut (.*);

  // Shadow copy of the frame store and the size registers.
  logic [NUM_CH-1:0][SAMPLE_W-1:0] pix_store [0:DEPTH-1];
  bit                              pix_written [0:DEPTH-1];
  logic [CFG_W-1:0]  cfg_in_w, cfg_in_h, cfg_out_w, cfg_out_h;
  logic [CHN_W-1:0]  cfg_chan;
  logic [STEP_W-1:0] step_x, step_y;

  pixel_t expected_px [$];

  int  cycle_cnt    = 0;
  int  err_cnt      = 0;
  int  items_sent   = 0;
  int  load_cnt     = 0;
  int  compute_cnt  = 0;
  int  results_seen = 0;
  int  sizes_set    = 0;
  int  hold_len     = 0;
  bit  tx_gaps_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results pending", cycle_cnt,
             expected_px.size());
    $display("** bilinear_downscaler: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
  endtask

  function automatic logic [STEP_W-1:0] ratio_q16(input logic [CFG_W-1:0] in_sz,
                                                  input logic [CFG_W-1:0] out_sz);
    int unsigned n, d;
    n = (in_sz < 1) ? 1 : in_sz;
    d = (out_sz < 1) ? 1 : out_sz;
    return STEP_W'(((n - 1) << FRAC_W) / d);
  endfunction

  function automatic int unsigned clamp_idx(input longint unsigned c, input int unsigned size,
                                            input int unsigned lim);
    int unsigned s;
    s = (size < 1) ? 1 : size;
    if (s > lim) s = lim;
    return (c > s - 1) ? s - 1 : int'(c);
  endfunction

  function automatic void find_neighbors(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                         output logic [3:0][ADDR_W-1:0] nb,
                                         output logic [3:0][63:0] wt);
    longint unsigned cx, cy, fx, fy, gx, gy;
    int unsigned x0, x1, y0, y1;
    cx = 64'(x) * 64'(step_x);
    cy = 64'(y) * 64'(step_y);
    fx = cx % 65536;
    fy = cy % 65536;
    gx = 65536 - fx;
    gy = 65536 - fy;
    x0 = clamp_idx(cx >> FRAC_W, cfg_in_w, MAX_WIDTH);
    x1 = clamp_idx((cx >> FRAC_W) + 1, cfg_in_w, MAX_WIDTH);
    y0 = clamp_idx(cy >> FRAC_W, cfg_in_h, MAX_HEIGHT);
    y1 = clamp_idx((cy >> FRAC_W) + 1, cfg_in_h, MAX_HEIGHT);
    nb[0] = ADDR_W'(y0 * MAX_WIDTH + x0);
    nb[1] = ADDR_W'(y0 * MAX_WIDTH + x1);
    nb[2] = ADDR_W'(y1 * MAX_WIDTH + x0);
    nb[3] = ADDR_W'(y1 * MAX_WIDTH + x1);
    wt[0] = gx * gy;
    wt[1] = fx * gy;
    wt[2] = gx * fy;
    wt[3] = fx * fy;
  endfunction

  function automatic pixel_t predict_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    logic [3:0][ADDR_W-1:0] nb;
    logic [3:0][63:0]       wt;
    longint unsigned        acc;
    int unsigned            nch;
    int                     c, k;
    pixel_t                 r;
    find_neighbors(x, y, nb, wt);
    nch = (cfg_chan > MAX_CHANNELS) ? MAX_CHANNELS : cfg_chan;
    r.x = x;
    r.y = y;
    r.v = '0;
    for (c = 0; c < NUM_CH; c++) begin
      if (c < nch) begin
        acc = 0;
        for (k = 0; k < 4; k++) acc += 64'(pix_store[nb[k]][c]) * wt[k];
        acc = acc >> 32;
        r.v[c] = (acc > 64'hFFFF) ? 16'hFFFF : acc[SAMPLE_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (!tx_gaps_on || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic logic [NUM_CH-1:0][SAMPLE_W-1:0] rand_pixel();
    logic [NUM_CH-1:0][SAMPLE_W-1:0] p;
    int                              c;
    int unsigned                     r;
    for (c = 0; c < NUM_CH; c++) begin
      r = $urandom_range(0, 7);
      p[c] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : SAMPLE_W'($urandom);
    end
    return p;
  endfunction

  function automatic logic [POS_W-1:0] pick_coord(input logic [CFG_W-1:0] size);
    int unsigned lim;
    lim = (size == 0) ? 0 : (size > 256) ? 255 : size - 1;
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, lim));
  endfunction

  function automatic logic [POS_W-1:0] pick_src(input logic [CFG_W-1:0] size,
                                                input int unsigned lim);
    int unsigned s;
    s = (size < 1) ? 1 : size;
    if (s > lim) s = lim;
    return POS_W'($urandom_range(0, s - 1));
  endfunction

  task automatic send_item(input logic op, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y,
                           input logic [NUM_CH-1:0][SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    pos_x_i    <= x;
    pos_y_i    <= y;
    sample_0_i <= smp[0];
    sample_1_i <= smp[1];
    sample_2_i <= smp[2];
    sample_3_i <= smp[3];
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (op == OP_LOAD) begin
      pix_store[{y, x}]   = smp;
      pix_written[{y, x}] = 1'b1;
      load_cnt++;
    end else begin
      expected_px.push_back(predict_pixel(x, y));
      compute_cnt++;
    end
  endtask

  // Loads any neighbor that has not been written yet, then asks for the pixel.
  task automatic send_compute(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    logic [3:0][ADDR_W-1:0] nb;
    logic [3:0][63:0]       wt;
    int                     k;
    find_neighbors(x, y, nb, wt);
    for (k = 0; k < 4; k++) begin
      if (!pix_written[nb[k]])
        send_item(OP_LOAD, nb[k][POS_W-1:0], nb[k][ADDR_W-1:POS_W], rand_pixel());
    end
    send_item(OP_COMPUTE, x, y, rand_pixel());
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input int unsigned val);
    logic [APB_DW-1:0] want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_IN_WIDTH:   cfg_in_w  = CFG_W'(val);
      REG_IN_HEIGHT:  cfg_in_h  = CFG_W'(val);
      REG_OUT_WIDTH:  cfg_out_w = CFG_W'(val);
      REG_OUT_HEIGHT: cfg_out_h = CFG_W'(val);
      REG_CHANNELS:   cfg_chan  = CHN_W'(val);
      default: ;
    endcase
    step_x = ratio_q16(cfg_in_w, cfg_out_w);
    step_y = ratio_q16(cfg_in_h, cfg_out_h);
    want = (idx == REG_CHANNELS) ? APB_DW'(cfg_chan) : APB_DW'(val & 32'h1FF);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned iw, input int unsigned ih, input int unsigned ow,
                           input int unsigned oh, input int unsigned ch);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_CHANNELS, ch);
    sizes_set++;
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : rx_stall_gen
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        hold_len = hold_len - 1;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left = stall_left - 1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = idle_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_t                          want;
    logic [NUM_CH-1:0][SAMPLE_W-1:0] got_v;
    int                              c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_v = {value_3_o, value_2_o, value_1_o, value_0_o};
      results_seen++;
      if (expected_px.size() == 0) begin
        report_mismatch("result with no compute pending, x", result_x_o, -1);
      end else begin
        want = expected_px.pop_front();
        if (result_x_o !== want.x) report_mismatch("result_x", result_x_o, want.x);
        if (result_y_o !== want.y) report_mismatch("result_y", result_y_o, want.y);
        for (c = 0; c < NUM_CH; c++) begin
          if (got_v[c] !== want.v[c])
            report_mismatch($sformatf("value_%0d at (%0d,%0d)", c, want.x, want.y),
                            got_v[c], want.v[c]);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_compute(8'd0, 8'd0);
    send_compute(8'd127, 8'd127);
    send_compute(8'd128, 8'd5);
    send_compute(8'd255, 8'd255);
  endtask

  task automatic test_directed_extremes();
    set_sizes(256, 256, 256, 256, 4);
    send_item(OP_LOAD, 8'd0, 8'd0, {4{16'h0000}});
    send_item(OP_LOAD, 8'd1, 8'd0, {4{16'hFFFF}});
    send_item(OP_LOAD, 8'd0, 8'd1, {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    send_item(OP_LOAD, 8'd1, 8'd1, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_item(OP_LOAD, 8'd255, 8'd255, {4{16'hFFFF}});
    send_item(OP_LOAD, 8'd254, 8'd255, {4{16'h0000}});
    send_item(OP_LOAD, 8'd255, 8'd254, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    send_item(OP_LOAD, 8'd254, 8'd254, {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE});
    send_compute(8'd0, 8'd0);
    send_compute(8'd1, 8'd0);
    send_compute(8'd0, 8'd1);
    send_compute(8'd1, 8'd1);
    send_compute(8'd255, 8'd255);
    send_compute(8'd254, 8'd254);
  endtask

  task automatic test_config_corners();
    int i;
    for (i = 0; i < 8; i++) begin
      case (i)
        0: set_sizes(256, 256, 256, 256, 4);
        1: set_sizes(2, 2, 1, 1, 1);
        2: set_sizes(0, 1, 0, 0, 0);
        3: set_sizes(511, 300, 1, 3, 7);
        4: set_sizes(256, 2, 256, 1, 5);
        5: set_sizes(2, 256, 1, 256, 4);
        6: set_sizes(17, 9, 5, 3, 2);
        default: set_sizes(1, 0, 256, 256, 3);
      endcase
      send_compute(8'd0, 8'd0);
      send_compute(8'd255, 8'd255);
      repeat (6) send_compute(pick_coord(cfg_out_w), pick_coord(cfg_out_h));
    end
  endtask

  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_len   = 400;
    repeat (20) send_compute(pick_coord(cfg_out_w), pick_coord(cfg_out_h));
    tx_gaps_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (10) send_compute(pick_coord(cfg_out_w), pick_coord(cfg_out_h));
    pause_until_drained();
    repeat (10) send_compute(pick_coord(cfg_out_w), pick_coord(cfg_out_h));
  endtask

  task automatic test_random_frames();
    int unsigned iw, ih, ow, oh, ch, r;
    int          n;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        iw = $urandom_range(0, 511);
        ih = $urandom_range(0, 511);
        ow = $urandom_range(0, 511);
        oh = $urandom_range(0, 511);
        ch = $urandom_range(0, 7);
      end else begin
        iw = $urandom_range(2, 256);
        ih = $urandom_range(2, 256);
        ow = $urandom_range(1, 256);
        oh = $urandom_range(1, 256);
        ch = $urandom_range(1, 4);
      end
      set_sizes(iw, ih, ow, oh, ch);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 70);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 60)
          send_compute(pick_coord(cfg_out_w), pick_coord(cfg_out_h));
        else if (r < 90)
          send_item(OP_LOAD, pick_src(cfg_in_w, MAX_WIDTH), pick_src(cfg_in_h, MAX_HEIGHT),
                    rand_pixel());
        else
          send_item(OP_LOAD, POS_W'($urandom), POS_W'($urandom), rand_pixel());
      end
    end
    tx_gaps_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    int i;
    cfg_in_w  = CFG_W'(IN_WIDTH_RST);
    cfg_in_h  = CFG_W'(IN_HEIGHT_RST);
    cfg_out_w = CFG_W'(OUT_WIDTH_RST);
    cfg_out_h = CFG_W'(OUT_HEIGHT_RST);
    cfg_chan  = CHN_W'(CHANNELS_RST);
    step_x    = ratio_q16(cfg_in_w, cfg_out_w);
    step_y    = ratio_q16(cfg_in_h, cfg_out_h);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_extremes();
    test_config_corners();
    test_backpressure();
    test_drain_pause();
    test_random_frames();

    in_valid_i <= 1'b0;
    for (i = 0; i < DRAIN_LIMIT && expected_px.size() != 0; i++) @(posedge clk_i);
    if (expected_px.size() != 0)
      report_mismatch("results never returned", 0, expected_px.size());
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run: %0d items (%0d loads, %0d computes), %0d results checked, %0d size settings.",
             items_sent, load_cnt, compute_cnt, results_seen, sizes_set);
    $display("Included edge clamping, degenerate and oversized sizes, 0 to 7 channels, %s",
             "a long output hold-off and a full drain.");
    if (err_cnt == 0) begin
      $display("** bilinear_downscaler: PASSED **");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("** bilinear_downscaler: FAILED **");
    end
    $finish;
  end

endmodule
